[hdl/flr_pkg.sv]
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants of the fixed-point line rasterizer
// Field widths, register indexes, function codes and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package flr_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 15;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed widths
  localparam int ACC_BITS    = 32;
  localparam int PIX_BITS    = 14;
  localparam int COLOR_BITS  = 8;
  localparam int CFG_BITS    = 15;
  localparam int CFG_IDX_BITS = 1;

  // Output word: pix_x, pix_y, pix_color, padded to whole bytes
  localparam int M_FIELD_BITS = 2 * PIX_BITS + COLOR_BITS;
  localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

  localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

  // Function codes carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET  = 15'd640;
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 15'd480;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;      // latch a new line, start the divider
    logic div_step;  // one quotient bit
    logic div_fin;   // write the signed increment
    logic emit;      // load the output register with the current pixel
    logic advance;   // move one unit along the long axis
  } flr_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic is_last;   // current position is the end point
  } flr_stat_t;

  // Largest coordinate allowed for an image size
  function automatic logic [PIX_BITS-1:0] clamp_limit(input logic [CFG_BITS-1:0] size);
    logic [CFG_BITS-1:0] hi;
    hi = size - CFG_BITS'(1);
    if (size == '0) return '0;
    if (hi > CFG_BITS'(PIX_MAX)) return PIX_MAX;
    return hi[PIX_BITS-1:0];
  endfunction

endpackage

[hdl/fixed_point_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer: 16.16 fixed-point line stepping engine
// Input stream: s_tuser = 0 loads a line (endpoints and colour), 1 asks for
// the next pixel. Output stream: one clamped pixel per step, tlast on the
// end point. Configuration: cfg_index 0 = image width, 1 = image height.
//
// A load word is accepted and then the increment divider runs one quotient
// bit per cycle, then signs the result in a final state; the next input
// word is taken only once the divider is through. Step words are taken one
// per cycle while the output is not held, and their pixel appears in the
// output register the cycle after acceptance. A step with no active line is
// taken and gives nothing; a load drops any line still being drawn.
// The output register holds a pixel while m_tready is low; s_tready then
// drops so no step is taken until the pixel moves on, and a new step is
// accepted in the same cycle the held pixel is taken.
// After reset no line is active and the image is 640 by 480. Configuration
// must be written by the user only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer #(
  parameter int COORD_BITS = flr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = flr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_x, start_y, end_x, end_y, pen_color (low bits first), zero padded
  input  logic [((4*COORD_BITS+flr_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // func
  input  logic                                s_tuser,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pix_x, pix_y, pix_color (low bits first), zero padded
  output logic [flr_pkg::M_DATA_BITS-1:0]     m_tdata,
  // last
  output logic                                m_tlast,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [flr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [flr_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int CB = COORD_BITS;

  flr_pkg::flr_cmd_t  cmd;
  flr_pkg::flr_stat_t stat;

  logic [flr_pkg::PIX_BITS-1:0]   pix_x;
  logic [flr_pkg::PIX_BITS-1:0]   pix_y;
  logic [flr_pkg::COLOR_BITS-1:0] pix_color;

  flr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  flr_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_x   ($signed(s_tdata[CB-1:0])),
    .start_y   ($signed(s_tdata[2*CB-1:CB])),
    .end_x     ($signed(s_tdata[3*CB-1:2*CB])),
    .end_y     ($signed(s_tdata[4*CB-1:3*CB])),
    .pen_color (s_tdata[4*CB+flr_pkg::COLOR_BITS-1:4*CB]),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .last      (m_tlast)
  );

  // Pack the output word
  assign m_tdata = flr_pkg::M_DATA_BITS'({pix_color, pix_y, pix_x});

endmodule

[hdl/flr_div.sv]
// ----------------------------------------------------------------------------
// flr_div: iterative restoring divider for the per-step increment
// Computes (dividend << FRAC_BITS) / divisor one quotient bit per step,
// for dividend <= divisor. FRAC_BITS + 1 steps give the full quotient.
// ----------------------------------------------------------------------------
module flr_div #(
  parameter int COORD_BITS = flr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = flr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  init,
  input  logic                  step,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0] divisor,
  output logic [FRAC_BITS:0]    quot
);

  logic [COORD_BITS-1:0] rem;
  logic [FRAC_BITS:0]    q;
  logic                  first;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  // first step tests the whole part, later steps shift in a zero
  always_comb begin
    trial = first ? {1'b0, rem} : {rem, 1'b0};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (init) begin
      rem   <= dividend;
      q     <= '0;
      first <= 1'b1;
    end else if (step) begin
      rem   <= ge ? COORD_BITS'(trial - {1'b0, divisor}) : trial[COORD_BITS-1:0];
      q     <= {q[FRAC_BITS-1:0], ge};
      first <= 1'b0;
    end
  end

  assign quot = q;

endmodule

[hdl/flr_dp.sv]
// ----------------------------------------------------------------------------
// flr_dp: datapath of the line rasterizer
// Image-size registers, line set-up, increment divider, 16.16 accumulator,
// coordinate clamps and the output register.
// ----------------------------------------------------------------------------
module flr_dp #(
  parameter int COORD_BITS = flr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = flr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  flr_pkg::flr_cmd_t                  cmd,
  output flr_pkg::flr_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [flr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [flr_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic signed [COORD_BITS-1:0]       start_x,
  input  logic signed [COORD_BITS-1:0]       start_y,
  input  logic signed [COORD_BITS-1:0]       end_x,
  input  logic signed [COORD_BITS-1:0]       end_y,
  input  logic [flr_pkg::COLOR_BITS-1:0]     pen_color,
  output logic [flr_pkg::PIX_BITS-1:0]       pix_x,
  output logic [flr_pkg::PIX_BITS-1:0]       pix_y,
  output logic [flr_pkg::COLOR_BITS-1:0]     pix_color,
  output logic                               last
);

  localparam int ACC_BITS = flr_pkg::ACC_BITS;
  localparam int PIX_BITS = flr_pkg::PIX_BITS;
  localparam int CLW      = ACC_BITS - FRAC_BITS;

  // Clamp limits, kept as width-1 / height-1
  logic [PIX_BITS-1:0] x_lim;
  logic [PIX_BITS-1:0] y_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lim <= flr_pkg::clamp_limit(flr_pkg::IMAGE_WIDTH_RESET);
      y_lim <= flr_pkg::clamp_limit(flr_pkg::IMAGE_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        flr_pkg::REG_IMAGE_WIDTH:  x_lim <= flr_pkg::clamp_limit(cfg_data);
        flr_pkg::REG_IMAGE_HEIGHT: y_lim <= flr_pkg::clamp_limit(cfg_data);
        default: ;
      endcase
    end
  end

  // Line set-up from the endpoints
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS-1:0]        ady;
  logic                         y_long_in;
  logic [COORD_BITS-1:0]        mag_s_in;
  logic [COORD_BITS-1:0]        mag_l_in;
  logic                         neg_in;
  logic                         l_neg_in;
  logic signed [COORD_BITS-1:0] s_start;

  always_comb begin
    dx        = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
    dy        = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
    adx       = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady       = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    y_long_in = ady > adx;
    mag_s_in  = y_long_in ? adx : ady;
    mag_l_in  = y_long_in ? ady : adx;
    l_neg_in  = y_long_in ? dy[COORD_BITS] : dx[COORD_BITS];
    neg_in    = (y_long_in ? dx[COORD_BITS] : dy[COORD_BITS]) ^ l_neg_in;
    s_start   = y_long_in ? start_x : start_y;
  end

  // Line state
  logic                         y_is_long_axis;
  logic                         step_down;
  logic                         inc_neg;
  logic                         l_zero;
  logic [COORD_BITS-1:0]        mag_l;
  logic signed [COORD_BITS-1:0] long_pos;
  logic signed [COORD_BITS-1:0] long_end;
  logic [ACC_BITS-1:0]          frac_acc;
  logic [ACC_BITS-1:0]          frac_inc;
  logic [flr_pkg::COLOR_BITS-1:0] line_color;
  logic [FRAC_BITS:0]           quot;
  logic [ACC_BITS-1:0]          inc_mag;

  flr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .init     (cmd.load),
    .step     (cmd.div_step),
    .dividend (mag_s_in),
    .divisor  (mag_l),
    .quot     (quot)
  );

  assign inc_mag = ACC_BITS'(quot);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_is_long_axis <= y_long_in;
      step_down      <= l_neg_in || (mag_l_in == '0);
      inc_neg        <= neg_in;
      l_zero         <= mag_l_in == '0;
      mag_l          <= mag_l_in;
      long_pos       <= y_long_in ? start_y : start_x;
      long_end       <= y_long_in ? end_y : end_x;
      // start coordinate plus one half
      frac_acc       <= {CLW'(s_start), 1'b1, {(FRAC_BITS-1){1'b0}}};
      line_color     <= pen_color;
    end else if (cmd.advance) begin
      if (step_down) begin
        long_pos <= long_pos - COORD_BITS'(1);
        frac_acc <= frac_acc - frac_inc;
      end else begin
        long_pos <= long_pos + COORD_BITS'(1);
        frac_acc <= frac_acc + frac_inc;
      end
    end
    // signed increment once the quotient is complete
    if (cmd.div_fin) begin
      frac_inc <= l_zero ? '0 : (inc_neg ? ACC_BITS'(-inc_mag) : inc_mag);
    end
  end

  assign stat.is_last = long_pos == long_end;

  // Pixel coordinates and clamps
  function automatic logic [PIX_BITS-1:0] clamp_pix(input logic signed [CLW-1:0] v,
                                                    input logic [PIX_BITS-1:0] lim);
    if (v[CLW-1]) return '0;
    if ($unsigned(v) > CLW'(lim)) return lim;
    return v[PIX_BITS-1:0];
  endfunction

  logic signed [CLW-1:0] acc_whole;
  logic signed [CLW-1:0] long_ext;
  logic signed [CLW-1:0] px;
  logic signed [CLW-1:0] py;

  always_comb begin
    acc_whole = $signed(frac_acc[ACC_BITS-1:FRAC_BITS]);
    long_ext  = CLW'(long_pos);
    px        = y_is_long_axis ? acc_whole : long_ext;
    py        = y_is_long_axis ? long_ext : acc_whole;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_x     <= clamp_pix(px, x_lim);
      pix_y     <= clamp_pix(py, y_lim);
      pix_color <= line_color;
      last      <= stat.is_last;
    end
  end

endmodule

[hdl/flr_ctrl.sv]
// ----------------------------------------------------------------------------
// flr_ctrl: controller of the line rasterizer
// Handshakes on both streams, sequences the increment division after a
// load and tracks whether a line is active.
// ----------------------------------------------------------------------------
module flr_ctrl #(
  parameter int FRAC_BITS = flr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               func,
  output logic               m_tvalid,
  input  logic               m_tready,
  output flr_pkg::flr_cmd_t  cmd,
  input  flr_pkg::flr_stat_t stat
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             line_active;
  logic             in_word;

  // Accept while running and the output register is free or draining
  always_comb begin
    s_tready     = (state == ST_RUN) && (!m_tvalid || m_tready);
    in_word      = s_tvalid && s_tready;
    cmd.load     = in_word && (func == flr_pkg::FUNC_LOAD);
    cmd.emit     = in_word && (func == flr_pkg::FUNC_STEP) && line_active;
    cmd.advance  = cmd.emit && !stat.is_last;
    cmd.div_step = state == ST_DIV;
    cmd.div_fin  = state == ST_FIN;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: if (cmd.load) state_next = ST_DIV;
      ST_DIV: if (cnt == CNT_W'(FRAC_BITS)) state_next = ST_FIN;
      ST_FIN: state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      cnt         <= '0;
      line_active <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      // quotient bit counter
      if (state == ST_DIV) cnt <= cnt + CNT_W'(1);
      else                 cnt <= '0;
      if (cmd.load)                        line_active <= 1'b1;
      else if (cmd.emit && stat.is_last)   line_active <= 1'b0;
      if (cmd.emit)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
